// ----- src/eupc_pkg.sv -----
package eupc_pkg;

    localparam logic [1:0] SYM_EAN8  = 2'd0;
    localparam logic [1:0] SYM_EAN13 = 2'd1;
    localparam logic [1:0] SYM_UPCA  = 2'd2;

    localparam logic [6:0] GUARD_SIDE   = 7'h50;
    localparam logic [6:0] GUARD_MIDDLE = 7'h28;

    localparam logic [2:0] CNT_NONE   = 3'd0;
    localparam logic [2:0] CNT_GUARD  = 3'd3;
    localparam logic [2:0] CNT_MIDDLE = 3'd5;
    localparam logic [2:0] CNT_DIGIT  = 3'd7;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIGIT  = 2'd1;
    localparam logic [1:0] ST_LENGTH = 2'd2;

    typedef enum logic [1:0] {
        KIND_L = 2'd0,
        KIND_G = 2'd1,
        KIND_R = 2'd2
    } kind_t;

    typedef struct packed {
        logic [6:0] modules;
        logic [2:0] module_count;
        logic       end_of_symbol;
        logic [1:0] status;
    } result_t;

    // up to three results caused by one digit, first one in res[0]
    typedef struct packed {
        logic [1:0]        count;
        result_t [2:0]     res;
    } grp_t;

    typedef struct packed {
        logic [3:0] digit_position;
        logic [3:0] weighted_sum_mod_ten;
        logic [5:0] parity_pattern;
        logic       discarding;
    } state_t;

    function automatic logic [6:0] l_code(input logic [3:0] d);
        logic [6:0] c;
        unique case (d)
            4'd0:    c = 7'h0D;
            4'd1:    c = 7'h19;
            4'd2:    c = 7'h13;
            4'd3:    c = 7'h3D;
            4'd4:    c = 7'h23;
            4'd5:    c = 7'h31;
            4'd6:    c = 7'h2F;
            4'd7:    c = 7'h3B;
            4'd8:    c = 7'h37;
            4'd9:    c = 7'h0B;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // L/G parity of digits 2..7 selected by the leading ean-13 digit, G = 1
    function automatic logic [5:0] first_parity(input logic [3:0] d);
        logic [5:0] c;
        unique case (d)
            4'd0:    c = 6'h00;
            4'd1:    c = 6'h0B;
            4'd2:    c = 6'h0D;
            4'd3:    c = 6'h0E;
            4'd4:    c = 6'h13;
            4'd5:    c = 6'h19;
            4'd6:    c = 6'h1C;
            4'd7:    c = 6'h15;
            4'd8:    c = 6'h16;
            4'd9:    c = 6'h1A;
            default: c = 6'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] digit_modules(input logic [3:0] d, input kind_t kind);
        logic [6:0] l;
        logic [6:0] r;
        logic [6:0] g;
        logic [6:0] m;
        l = l_code(d);
        r = ~l;
        for (int i = 0; i < 7; i++) begin
            g[i] = r[6 - i];
        end
        unique case (kind)
            KIND_L:  m = l;
            KIND_G:  m = g;
            KIND_R:  m = r;
            default: m = r;
        endcase
        return m;
    endfunction

    // values stay below 64
    function automatic logic [3:0] mod10(input logic [5:0] v);
        logic [5:0] m;
        priority if (v >= 6'd60) m = v - 6'd60;
        else if (v >= 6'd50)     m = v - 6'd50;
        else if (v >= 6'd40)     m = v - 6'd40;
        else if (v >= 6'd30)     m = v - 6'd30;
        else if (v >= 6'd20)     m = v - 6'd20;
        else if (v >= 6'd10)     m = v - 6'd10;
        else                     m = v;
        return m[3:0];
    endfunction

endpackage

// ----- src/eupc_step.sv -----
module eupc_step (
    input  logic [1:0]      symbology,
    input  eupc_pkg::state_t state,
    input  logic [3:0]      digit,
    input  logic            last_digit,
    output eupc_pkg::grp_t  grp,
    output eupc_pkg::state_t state_next
);

    always_comb begin
        logic                  ean8;
        logic                  lead;
        logic                  first;
        logic                  len_err;
        logic                  w3;
        logic                  drawn;
        logic                  mid;
        logic                  chk;
        logic [3:0]            total;
        logic [3:0]            checkpos;
        logic [3:0]            p;
        logic [4:0]            p_inc;
        logic [3:0]            wsum_base;
        logic [5:0]            parity_base;
        logic [5:0]            wsum_acc;
        logic [3:0]            wsum_new;
        logic [5:0]            parity_new;
        logic [3:0]            chk_digit;
        logic [5:0]            par_shift;
        eupc_pkg::kind_t       kind;
        eupc_pkg::result_t     cand [5];
        logic [4:0]            cand_en;
        logic [1:0]            n;

        ean8     = (symbology == eupc_pkg::SYM_EAN8);
        lead     = !ean8 && symbology[1];
        total    = ean8 ? 4'd8 : 4'd13;
        checkpos = total - 4'd1;
        first    = (state.digit_position == 4'd0);
        p        = (first && lead) ? 4'd1 : state.digit_position;
        p_inc    = {1'b0, p} + 5'd1;
        len_err  = (p >= total) || (last_digit && (p_inc < {1'b0, checkpos}));

        // upc-a implies the leading zero, which contributes nothing
        wsum_base   = (first && lead) ? 4'd0 : state.weighted_sum_mod_ten;
        parity_base = (first && lead) ? 6'd0 : state.parity_pattern;

        // weight 3 on digits an odd distance before the check position
        w3       = checkpos[0] ^ p[0];
        wsum_acc = {2'b00, wsum_base} + {2'b00, digit}
                 + (w3 ? {1'b0, digit, 1'b0} : 6'd0);
        wsum_new = eupc_pkg::mod10(wsum_acc);

        parity_new = (!ean8 && (p == 4'd0)) ? eupc_pkg::first_parity(digit) : parity_base;

        par_shift = parity_base >> (3'd6 - p[2:0]);
        if (ean8) begin
            kind = (p < 4'd4) ? eupc_pkg::KIND_L : eupc_pkg::KIND_R;
        end else if (p <= 4'd6) begin
            kind = par_shift[0] ? eupc_pkg::KIND_G : eupc_pkg::KIND_L;
        end else begin
            kind = eupc_pkg::KIND_R;
        end

        drawn     = ean8 || (p != 4'd0);
        mid       = ean8 ? (p == 4'd3) : (p == 4'd6);
        chk       = last_digit && (p_inc == {1'b0, checkpos});
        chk_digit = (wsum_new == 4'd0) ? 4'd0 : 4'd10 - wsum_new;

        cand[0] = '{eupc_pkg::GUARD_SIDE, eupc_pkg::CNT_GUARD, 1'b0, eupc_pkg::ST_OK};
        cand[1] = '{eupc_pkg::digit_modules(digit, kind), eupc_pkg::CNT_DIGIT, 1'b0,
                    eupc_pkg::ST_OK};
        cand[2] = '{eupc_pkg::GUARD_MIDDLE, eupc_pkg::CNT_MIDDLE, 1'b0, eupc_pkg::ST_OK};
        cand[3] = '{eupc_pkg::digit_modules(chk_digit, eupc_pkg::KIND_R),
                    eupc_pkg::CNT_DIGIT, 1'b0, eupc_pkg::ST_OK};
        cand[4] = '{eupc_pkg::GUARD_SIDE, eupc_pkg::CNT_GUARD, 1'b1, eupc_pkg::ST_OK};
        cand_en = {last_digit, chk, mid, drawn, first};

        grp        = '0;
        state_next = state;
        n          = 2'd0;

        if (state.discarding) begin
            state_next.discarding = !last_digit;
        end else if (len_err || (digit > 4'd9)) begin
            grp.count  = 2'd1;
            grp.res[0] = '{7'd0, eupc_pkg::CNT_NONE, 1'b1,
                           len_err ? eupc_pkg::ST_LENGTH : eupc_pkg::ST_DIGIT};
            state_next            = '0;
            state_next.discarding = !last_digit;
        end else begin
            // pack the enabled groups in symbol order, never more than three
            for (int i = 0; i < 5; i++) begin
                if (cand_en[i] && (n != 2'd3)) begin
                    grp.res[n] = cand[i];
                    n          = n + 2'd1;
                end
            end
            grp.count                       = n;
            state_next.digit_position       = p_inc[3:0];
            state_next.weighted_sum_mod_ten = wsum_new;
            state_next.parity_pattern       = parity_new;
            if (last_digit) begin
                state_next = '0;
            end
        end
    end

endmodule

// ----- src/eupc_res_buf.sv -----
module eupc_res_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  eupc_pkg::grp_t    grp,
    output logic              free,
    output logic              m_valid,
    input  logic              m_ready,
    output eupc_pkg::result_t m_res
);

    eupc_pkg::result_t [2:0] buf_reg;
    eupc_pkg::result_t [2:0] buf_next;
    logic [1:0]              cnt_reg;
    logic [1:0]              cnt_next;
    logic                    take;

    assign m_valid = (cnt_reg != 2'd0);
    assign take    = m_valid && m_ready;
    assign free    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_ready);
    assign m_res   = buf_reg[0];

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load) begin
            buf_next = grp.res;
            cnt_next = grp.count;
        end else if (take) begin
            // head leaves, the rest moves up
            buf_next[0] = buf_reg[1];
            buf_next[1] = buf_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg <= buf_next;
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- src/ean_upc_barcode_module_encoder.sv -----
// EAN-8 / EAN-13 / UPC-A module encoder. Digits come in one request at a
// time; each digit leaves zero to three module groups on the m_ side (start
// guard, 7-module L/G/R digit, middle guard, computed check digit, end
// guard), one group per request, first module in bit 6 of m_modules. An
// accepted digit is held in an input register until the result buffer
// is free, is encoded in a single pass and moves as a group of up to
// three results into a shift buffer, whose head is the m_ side result.
// The output side moves one result per cycle while m_ready is high. A
// digit leaves one result in most positions and up to three at the end
// of a symbol, and a digit that is discarded after an error leaves none.
// Symbology must be written through cfg_wen/cfg_wdata only while the
// block is idle; the block itself does not enforce this.
module ean_upc_barcode_module_encoder (
    input  logic       aclk,
    input  logic       aresetn,

    // configuration: symbology register
    input  logic       cfg_wen,
    input  logic [1:0] cfg_wdata,

    // digit requests
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_digit,
    input  logic       s_last_digit,

    // module group requests
    output logic       m_valid,
    input  logic       m_ready,
    output logic [6:0] m_modules,
    output logic [2:0] m_module_count,
    output logic       m_end_of_symbol,
    output logic [1:0] m_status
);

    // symbology, resets to ean-13
    logic [1:0]        symbology_reg;

    // input register
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [3:0]        in_digit_reg;
    logic              in_last_reg;

    // symbol state carried from digit to digit
    eupc_pkg::state_t  state_reg;
    eupc_pkg::state_t  state_next;

    eupc_pkg::grp_t    grp;
    eupc_pkg::result_t m_res;
    logic              buf_free;
    logic              load;
    logic              s_take;

    // the held digit moves on when the result buffer can take its group
    assign load    = in_valid_reg && buf_free;
    assign s_ready = !in_valid_reg || load;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (load) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_digit_reg <= s_digit;
            in_last_reg  <= s_last_digit;
        end
        if (!aresetn) begin
            symbology_reg <= eupc_pkg::SYM_EAN13;
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (cfg_wen) begin
                symbology_reg <= cfg_wdata;
            end
            in_valid_reg <= in_valid_next;
            // state advances only when a digit is encoded
            if (load) begin
                state_reg <= state_next;
            end
        end
    end

    // single-pass digit encoder
    eupc_step u_step (
        .symbology  (symbology_reg),
        .state      (state_reg),
        .digit      (in_digit_reg),
        .last_digit (in_last_reg),
        .grp        (grp),
        .state_next (state_next)
    );

    // result buffer, drains one group per cycle while m_ready is high
    eupc_res_buf u_res_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .grp     (grp),
        .free    (buf_free),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_modules       = m_res.modules;
    assign m_module_count  = m_res.module_count;
    assign m_end_of_symbol = m_res.end_of_symbol;
    assign m_status        = m_res.status;

    // error results are empty and close the symbol
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != eupc_pkg::ST_OK)) |->
            (m_end_of_symbol && (m_module_count == eupc_pkg::CNT_NONE)
             && (m_modules == 7'd0)))
        else $error("error result with modules or open symbol");

    // a closing ok result is always the end guard
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_symbol && (m_status == eupc_pkg::ST_OK)) |->
            ((m_module_count == eupc_pkg::CNT_GUARD)
             && (m_modules == eupc_pkg::GUARD_SIDE)))
        else $error("symbol closed without end guard");

    // a stalled input side means a digit is held
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && !buf_free))
        else $error("input stalled with nothing held");

    // a held digit that cannot move stays held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !buf_free) |=> in_valid_reg)
        else $error("held digit lost");

endmodule
